### rtl/lfu_table_with_spill_top_macros.svh
// Assertion macros shared by the table RTL.
`ifndef LFU_TABLE_WITH_SPILL_TOP_MACROS_SVH
`define LFU_TABLE_WITH_SPILL_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfu table: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LFU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfu table: next-cycle check failed");

`endif

### rtl/lfu_pkg.sv
// Constants, codes and types of the LFU table with spill.
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int DISK_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int CAPC_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ENTRY_W    = KEY_W + VAL_W + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  localparam logic CFG_RAM_CAP  = 1'b0;
  localparam logic CFG_DISK_CAP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED    = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_EVICTED    = 3'd2,
    ST_GET_HIT    = 3'd3,
    ST_GET_MISS   = 3'd4,
    ST_SPILL_FULL = 3'd5
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

endpackage

### rtl/lfu_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lfu_table_with_spill_top.sv
// Top level of the LFU key-value table with spill of evicted pairs.
//
//  channel  | direction | signals                        | content
//  ---------+-----------+--------------------------------+------------------------------
//  s_axis   | in        | tvalid/tready/tdata/tuser      | request: operation, key, value
//  m_axis   | out       | tvalid/tready/tdata/tuser      | result: status, read, spill
//  cfg      | in        | valid/ready/index/data         | ram_capacity, disk_capacity
//
// A request is accepted in the idle state; the scan state then reads the slot RAM out one
// entry per cycle, one slot after another, and the write state writes back the slot and
// loads the result register.
// A result still waiting on m_axis holds the write-back cycle until taken.
// Reset clears the valid bits at once; the slot RAM needs no clearing pass.
`timescale 1ns / 1ps
`include "lfu_table_with_spill_top_macros.svh"
module lfu_table_with_spill_top
  import lfu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // key [31:0], value [63:32]
  input  logic                 s_axis_tuser,   // operation
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [95:0]          m_axis_tdata,   // read_value, evicted_key, evicted_value
  output logic [STATUS_W-1:0]  m_axis_tuser,   // status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [DISK_W-1:0]    cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]          state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    used_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [ENTRIES-1:0]  valid_d;
  logic [DISK_W-1:0]   evict_total_q;
  logic [CAP_W-1:0]    ram_cap_q;
  logic [DISK_W-1:0]   disk_cap_q;

  logic                op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VAL_W-1:0]    value_q;

  logic                hit_q, free_q, vic_q;
  logic [IDX_W-1:0]    hit_idx_q, free_idx_q, vic_idx_q;
  logic [VAL_W-1:0]    hit_val_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  entry_t              vic_ent_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [VAL_W-1:0]    out_rd_q;
  logic [KEY_W-1:0]    out_ek_q;
  logic [VAL_W-1:0]    out_ev_q;

  // RAM side
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]  ram_rdata_raw;

  // scan side
  logic [IDX_W-1:0]    scan_idx;
  logic                scan_valid;
  logic                in_accept;
  logic                load_out;

  // write step
  status_e             status_w;
  logic [VAL_W-1:0]    rd_w;
  logic [KEY_W-1:0]    ek_w;
  logic [VAL_W-1:0]    ev_w;
  logic                clr_vic_w, set_valid_w, inc_evict_w;
  logic [CAPC_W-1:0]   cap_raw, cap_eff;
  logic                need_evict;
  logic [COUNT_BITS-1:0] hit_cnt_inc;

  lfu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Slot 0 is read while idle so its data is ready the cycle after accept.
  assign ram_raddr  = (state_q == S_SCAN) ? cnt_q[IDX_W-1:0] : '0;
  assign scan_idx   = IDX_W'(cnt_q - CNT_W'(1));
  assign scan_valid = valid_q[scan_idx];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign load_out        = (state_q == S_WRITE) && (!out_valid_q || m_axis_tready);

  assign cap_raw    = CAPC_W'(ram_cap_q);
  assign cap_eff    = (ram_cap_q == '0) ? CAPC_W'(1) :
                      ((cap_raw > CAPC_W'(ENTRIES)) ? CAPC_W'(ENTRIES) : cap_raw);
  assign need_evict = CAPC_W'(used_q) >= cap_eff;
  assign hit_cnt_inc = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1;

  always_comb begin
    status_w    = ST_GET_MISS;
    rd_w        = '0;
    ek_w        = '0;
    ev_w        = '0;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx_q;
    ram_wdata   = '{key: key_q, value: value_q, count: COUNT_BITS'(1)};
    clr_vic_w   = 1'b0;
    set_valid_w = 1'b0;
    inc_evict_w = 1'b0;
    if (op_q == OP_GET) begin
      if (hit_q) begin
        status_w  = ST_GET_HIT;
        rd_w      = hit_val_q;
        ram_we    = 1'b1;
        ram_wdata = '{key: key_q, value: hit_val_q, count: hit_cnt_inc};
      end
    end else if (hit_q) begin
      status_w  = ST_UPDATED;
      ram_we    = 1'b1;
      ram_wdata = '{key: key_q, value: value_q, count: hit_cnt_inc};
    end else if (need_evict) begin
      if (evict_total_q >= disk_cap_q) begin
        status_w = ST_SPILL_FULL;
      end else if (vic_q) begin
        status_w    = ST_EVICTED;
        ek_w        = vic_ent_q.key;
        ev_w        = vic_ent_q.value;
        clr_vic_w   = 1'b1;
        set_valid_w = 1'b1;
        inc_evict_w = 1'b1;
        ram_we      = 1'b1;
        // lowest free slot once the victim is gone
        ram_waddr   = (free_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
      end else begin
        status_w = ST_INSERTED;
      end
    end else begin
      status_w    = ST_INSERTED;
      ram_waddr   = free_idx_q;
      ram_we      = free_q;
      set_valid_w = free_q;
    end
    // write back only when the result can be loaded
    if (!load_out) begin
      ram_we      = 1'b0;
      clr_vic_w   = 1'b0;
      set_valid_w = 1'b0;
      inc_evict_w = 1'b0;
    end
  end

  // Drop the victim first, then mark the written slot.
  always_comb begin
    valid_d = valid_q;
    if (clr_vic_w) begin
      valid_d[vic_idx_q] = 1'b0;
    end
    if (set_valid_w) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      used_q        <= '0;
      valid_q       <= '0;
      evict_total_q <= '0;
      ram_cap_q     <= CAP_W'(16);
      disk_cap_q    <= {DISK_W{1'b1}};
      hit_q         <= 1'b0;
      free_q        <= 1'b0;
      vic_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RAM_CAP:  ram_cap_q  <= cfg_data[CAP_W-1:0];
          CFG_DISK_CAP: disk_cap_q <= cfg_data;
          default:      ;
        endcase
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_SCAN;
            cnt_q   <= CNT_W'(1);
            used_q  <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            vic_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (scan_valid) begin
            used_q <= used_q + CNT_W'(1);
            if (ram_rdata.key == key_q) begin
              hit_q <= 1'b1;
            end
            vic_q <= 1'b1;
          end else begin
            free_q <= 1'b1;
          end
          if (cnt_q == CNT_W'(ENTRIES)) begin
            state_q <= S_WRITE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_WRITE: begin
          if (load_out) begin
            state_q <= S_IDLE;
            valid_q <= valid_d;
            if (inc_evict_w) begin
              evict_total_q <= evict_total_q + DISK_W'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload: request, scan trackers, result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= s_axis_tuser;
      key_q   <= s_axis_tdata[KEY_W-1:0];
      value_q <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (state_q == S_SCAN) begin
      if (scan_valid && (ram_rdata.key == key_q) && !hit_q) begin
        hit_idx_q <= scan_idx;
        hit_val_q <= ram_rdata.value;
        hit_cnt_q <= ram_rdata.count;
      end
      if (!scan_valid && !free_q) begin
        free_idx_q <= scan_idx;
      end
      if (scan_valid && (!vic_q || (ram_rdata.count < vic_ent_q.count) ||
          ((ram_rdata.count == vic_ent_q.count) && (ram_rdata.key < vic_ent_q.key)))) begin
        vic_idx_q <= scan_idx;
        vic_ent_q <= ram_rdata;
      end
    end
    if (load_out) begin
      out_status_q <= status_w;
      out_rd_q     <= rd_w;
      out_ek_q     <= ek_w;
      out_ev_q     <= ev_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_ev_q, out_ek_q, out_rd_q};

  `LFU_ASSERT_IMP(a_scan_range, state_q == S_SCAN, (cnt_q != '0) && (cnt_q <= CNT_W'(ENTRIES)))
  `LFU_ASSERT_NXT(a_evict_count, inc_evict_w,
                  evict_total_q == $past(evict_total_q) + DISK_W'(1))
  `LFU_ASSERT_NXT(a_insert_valid, set_valid_w, valid_q[$past(ram_waddr)])

endmodule

### bench/lfu_table_with_spill_top_test.sv
// Self-checking testbench of the LFU key-value table with spill of evicted pairs.
`timescale 1ns / 1ps
module lfu_table_with_spill_top_test;
  import lfu_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 7;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES      = 2 * ENTRIES + 8;
  localparam int KEY_POOL_SIZE    = 24;
  localparam int HOT_GETS         = 40;
  localparam int MAX_PRINTS       = 60;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] read_value;
    logic [KEY_W-1:0] evicted_key;
    logic [VAL_W-1:0] evicted_value;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata;   // key [31:0], value [63:32]
  logic                s_axis_tuser;   // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [95:0]         m_axis_tdata;   // read_value, evicted_key, evicted_value
  logic [STATUS_W-1:0] m_axis_tuser;   // status
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [DISK_W-1:0]   cfg_data;

  // Shadow copy of the table, its eviction total and its registers
  logic                  tbl_valid [ENTRIES];
  logic [KEY_W-1:0]      tbl_key   [ENTRIES];
  logic [VAL_W-1:0]      tbl_value [ENTRIES];
  logic [COUNT_BITS-1:0] tbl_count [ENTRIES];
  logic [DISK_W-1:0]     tbl_evictions;
  logic [CAP_W-1:0]      reg_ram_cap;
  logic [DISK_W-1:0]     reg_disk_cap;

  outcome_t         pending_outcomes[$];
  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];
  int               error_count;
  bit               src_idle_en;
  bit               sink_idle_en;
  bit               long_hold_req;

  lfu_table_with_spill_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Apply one request to the shadow table and return the result it produces.
  function automatic outcome_t lfu_outcome(input logic op, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val);
    outcome_t o;
    int       hit;
    int       victim;
    int       free_slot;
    int       used;
    int       cap;
    o.status        = ST_GET_MISS;
    o.read_value    = '0;
    o.evicted_key   = '0;
    o.evicted_value = '0;
    hit       = -1;
    victim    = -1;
    free_slot = -1;
    used      = 0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == key) hit = i;
    end
    if (hit >= 0) begin
      if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 1'b1;
      if (op == OP_GET) begin
        o.status     = ST_GET_HIT;
        o.read_value = tbl_value[hit];
      end else begin
        o.status       = ST_UPDATED;
        tbl_value[hit] = val;
      end
    end else if (op == OP_ADD) begin
      cap = reg_ram_cap;
      if (cap == 0) cap = 1;
      if (cap > ENTRIES) cap = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i]) used++;
      end
      o.status = ST_INSERTED;
      if (used >= cap) begin
        if (tbl_evictions >= reg_disk_cap) begin
          o.status = ST_SPILL_FULL;
        end else begin
          // least count wins, ties go to the smallest key
          for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && (victim < 0 || tbl_count[i] < tbl_count[victim] ||
                (tbl_count[i] == tbl_count[victim] && tbl_key[i] < tbl_key[victim])))
              victim = i;
          end
          o.status          = ST_EVICTED;
          o.evicted_key     = tbl_key[victim];
          o.evicted_value   = tbl_value[victim];
          tbl_valid[victim] = 1'b0;
          tbl_evictions     = tbl_evictions + 1'b1;
        end
      end
      if (o.status != ST_SPILL_FULL) begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) free_slot = i;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot]   = key;
        tbl_value[free_slot] = val;
        tbl_count[free_slot] = 1;
      end
    end
    return o;
  endfunction

  // Offer one request beat; valid stays high after acceptance until the next negedge.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] val);
    int gap;
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {val, key};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.push_back(lfu_outcome(op, key, val));
  endtask

  task automatic drain_results;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [DISK_W-1:0] data);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_RAM_CAP) reg_ram_cap = data[CAP_W-1:0];
    else reg_disk_cap = data;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [DISK_W-1:0] ram_cap, input logic [DISK_W-1:0] disk_cap);
    drain_results;
    write_reg(CFG_RAM_CAP, ram_cap);
    write_reg(CFG_DISK_CAP, disk_cap);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  task automatic run_random(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_request(($urandom_range(0, 9) < 4) ? OP_GET : OP_ADD, pick_key(), pick_value());
    end
  endtask

  task automatic test_basic_ops;
    send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_ADD, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
  endtask

  task automatic test_capacity_edges;
    // capacity zero acts as one, and is below the current occupancy of two
    drain_results;
    write_reg(CFG_RAM_CAP, 16'd0);
    send_request(OP_ADD, 32'h0000_0007, 32'hA5A5_A5A5);
    send_request(OP_ADD, 32'h0000_0008, 32'h5A5A_5A5A);
    // no spill room: inserts fail, updates still go through
    drain_results;
    write_reg(CFG_DISK_CAP, 16'h0000);
    send_request(OP_ADD, 32'h0000_0009, 32'hDEAD_0001);
    send_request(OP_ADD, 32'h0000_0000, 32'hDEAD_BEEF);
    send_request(OP_GET, 32'h0000_0009, 32'h0000_0000);
    // capacity above the table size acts as the table size
    set_config(16'd31, 16'hFFFF);
    for (int i = 0; i < 15; i++) send_request(OP_ADD, 32'd100 + i, $urandom());
  endtask

  task automatic test_hot_key;
    logic [KEY_W-1:0] hot_key;
    hot_key      = 32'h5A5A_0001;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config(16'd16, 16'hFFFF);
    send_request(OP_ADD, hot_key, 32'hC0DE_0001);
    for (int i = 0; i < HOT_GETS; i++) send_request(OP_GET, hot_key, 32'h0);
    // the heavily used key outranks every newcomer and survives the evictions
    set_config(16'd2, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_request(OP_ADD, 32'h7000_0000 + i, $urandom());
    send_request(OP_GET, hot_key, 32'h0);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_mix;
    set_config(16'd16, 16'hFFFF);
    run_random(300);
    set_config(16'd4, 16'hFFFF);
    run_random(300);
    set_config(16'd1, 16'hFFFF);
    run_random(200);
    // upper bits beyond the capacity field are dropped
    drain_results;
    write_reg(CFG_RAM_CAP, 16'hFFE0);
    run_random(150);
    set_config(DISK_W'($urandom_range(2, 15)),
               DISK_W'(tbl_evictions + $urandom_range(3, 10)));
    run_random(300);
  endtask

  task automatic test_backpressure;
    set_config(16'd31, 16'hFFFF);
    src_idle_en   = 1'b0;
    long_hold_req = 1'b1;
    run_random(60);
    src_idle_en = 1'b1;
    run_random(190);
    set_config(16'd20, 16'h0000);
    run_random(200);
  endtask

  task automatic test_streaming_tail;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    set_config(DISK_W'($urandom_range(1, 16)), 16'hFFFF);
    run_random(300);
  endtask

  initial begin : receiver
    int hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD_CYCLES;
      end
      if (hold > 0) begin
        m_axis_tready = 1'b0;
        hold--;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        hold          = $urandom_range(1, 11) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin : result_checker
    outcome_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
          if (m_axis_tdata[31:0] !== want.read_value)
            report_mismatch($sformatf("read_value %h, want %h",
                                      m_axis_tdata[31:0], want.read_value));
          if (m_axis_tdata[63:32] !== want.evicted_key)
            report_mismatch($sformatf("evicted_key %h, want %h",
                                      m_axis_tdata[63:32], want.evicted_key));
          if (m_axis_tdata[95:64] !== want.evicted_value)
            report_mismatch($sformatf("evicted_value %h, want %h",
                                      m_axis_tdata[95:64], want.evicted_value));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : main
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ADD;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_RAM_CAP;
    cfg_data      = '0;
    error_count   = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    long_hold_req = 1'b0;
    tbl_evictions = '0;
    reg_ram_cap   = 5'd16;
    reg_disk_cap  = 16'hFFFF;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
      tbl_count[i] = '0;
    end
    // small keys give count ties, the rest spread over the key space
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = i - 1;
    for (int i = 12; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops;
    test_capacity_edges;
    test_hot_key;
    test_random_mix;
    test_backpressure;
    test_streaming_tail;

    drain_results;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_table_with_spill_top.sv
bench/lfu_table_with_spill_top_test.sv
